// ===== rtl/core/signed_binary_to_decimal_ascii_macros.svh =====
// assertion macros for the signed binary to decimal ascii converter
`ifndef SIGNED_BINARY_TO_DECIMAL_ASCII_MACROS_SVH
`define SIGNED_BINARY_TO_DECIMAL_ASCII_MACROS_SVH

// checked only while out of reset
`define SB2DA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked at every edge, reset included
`define SB2DA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== rtl/core/sb2da_pkg.sv =====
// constants, types and helpers of the signed binary to decimal ascii converter
package sb2da_pkg;

  localparam int unsigned InWidth    = 32;
  localparam int unsigned CharWidth  = 7;
  localparam int unsigned ValueWidth = 32;

  function automatic int unsigned decimal_digits(input int unsigned width);
    logic [63:0] m;
    int unsigned n;
    m = 64'd1 << (width - 1);
    n = 0;
    for (int i = 0; i < 20; i++) begin
      if (m != 64'd0) begin
        m = m / 64'd10;
        n = n + 1;
      end
    end
    return n;
  endfunction

  localparam int unsigned NumDigits = decimal_digits(ValueWidth);
  localparam int unsigned BcdWidth  = 4 * NumDigits;
  localparam int unsigned StepCntW  = $clog2(ValueWidth + 1);
  localparam int unsigned DigCntW   = $clog2(NumDigits + 1);

  localparam logic [CharWidth-1:0] CharZero  = 7'h30;
  localparam logic [CharWidth-1:0] CharMinus = 7'h2D;

  typedef enum logic [4:0] {
    StIdle = 5'b00001,
    StConv = 5'b00010,
    StSkip = 5'b00100,
    StSign = 5'b01000,
    StDigs = 5'b10000
  } state_e;

  // add 3 to every bcd digit of five or more
  function automatic logic [BcdWidth-1:0] bcd_adjust(input logic [BcdWidth-1:0] bcd);
    logic [BcdWidth-1:0] res;
    res = bcd;
    for (int d = 0; d < NumDigits; d++) begin
      if (bcd[4*d +: 4] >= 4'd5) begin
        res[4*d +: 4] = bcd[4*d +: 4] + 4'd3;
      end
    end
    return res;
  endfunction

endpackage

// ===== rtl/core/sb2da_if.sv =====
// channel interfaces of the signed binary to decimal ascii converter
interface sb2da_in_if import sb2da_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [InWidth-1:0]  value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface sb2da_out_if import sb2da_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CharWidth-1:0]  character;
  logic                  last;

  modport source (output valid, output character, output last, input ready);
  modport sink   (input valid, input character, input last, output ready);
endinterface

// ===== rtl/core/signed_binary_to_decimal_ascii.sv =====
// signed binary to decimal ascii converter, top level
//
// in_i takes one signed number per transaction; out_o returns its decimal
// text one character per transaction, '-' first for a negative number, no
// leading zeros, a single '0' for zero, last set on the final character.
// The number is turned into bcd by a shift-and-add-3 unit that handles one
// bit per cycle. Leading zero digits are then dropped at one digit per
// cycle, after which one character is loaded per cycle into the output
// register while out_o does not stall. in_i is ready only once the
// previous item's last character sits in the output register.
// A stall on out_o holds the output register and the sequencer; nothing is
// lost or repeated. Reset empties the output register and returns the
// sequencer to idle with in_i ready.
`include "signed_binary_to_decimal_ascii_macros.svh"

module signed_binary_to_decimal_ascii import sb2da_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  sb2da_in_if.sink      in_i,
  sb2da_out_if.source   out_o
);

  state_e                  state_q, state_d;
  logic [ValueWidth-1:0]   mag_q, mag_d;
  logic [BcdWidth-1:0]     bcd_q, bcd_d;
  logic                    neg_q, neg_d;
  logic [StepCntW-1:0]     step_q, step_d;
  logic [DigCntW-1:0]      dig_q, dig_d;
  logic                    out_valid_q, out_valid_d;
  logic [CharWidth-1:0]    char_q, char_d;
  logic                    last_q, last_d;

  logic [ValueWidth-1:0]   raw;
  logic [BcdWidth-1:0]     bcd_adj;
  logic [3:0]              top_digit;
  logic                    slot_free;
  logic                    load;

  assign raw       = ValueWidth'(in_i.value);
  assign bcd_adj   = bcd_adjust(bcd_q);
  assign top_digit = bcd_q[BcdWidth-1 -: 4];
  assign slot_free = !out_valid_q || out_o.ready;

  assign in_i.ready      = (state_q == StIdle);
  assign out_o.valid     = out_valid_q;
  assign out_o.character = char_q;
  assign out_o.last      = last_q;

  always_comb begin
    state_d = state_q;
    mag_d   = mag_q;
    bcd_d   = bcd_q;
    neg_d   = neg_q;
    step_d  = step_q;
    dig_d   = dig_q;
    char_d  = char_q;
    last_d  = last_q;
    load    = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (in_i.valid) begin
          neg_d   = raw[ValueWidth-1];
          mag_d   = raw[ValueWidth-1] ? (~raw + ValueWidth'(1)) : raw;
          bcd_d   = '0;
          step_d  = StepCntW'(ValueWidth);
          state_d = StConv;
        end
      end
      StConv: begin
        bcd_d  = {bcd_adj[BcdWidth-2:0], mag_q[ValueWidth-1]};
        mag_d  = {mag_q[ValueWidth-2:0], 1'b0};
        step_d = step_q - StepCntW'(1);
        if (step_q == StepCntW'(1)) begin
          dig_d   = DigCntW'(NumDigits);
          state_d = StSkip;
        end
      end
      StSkip: begin
        if (top_digit == 4'd0 && dig_q != DigCntW'(1)) begin
          bcd_d = {bcd_q[BcdWidth-5:0], 4'd0};
          dig_d = dig_q - DigCntW'(1);
        end else if (neg_q) begin
          state_d = StSign;
        end else begin
          state_d = StDigs;
        end
      end
      StSign: begin
        if (slot_free) begin
          load    = 1'b1;
          char_d  = CharMinus;
          last_d  = 1'b0;
          state_d = StDigs;
        end
      end
      StDigs: begin
        if (slot_free) begin
          load   = 1'b1;
          char_d = CharZero + {3'b000, top_digit};
          last_d = (dig_q == DigCntW'(1));
          bcd_d  = {bcd_q[BcdWidth-5:0], 4'd0};
          dig_d  = dig_q - DigCntW'(1);
          if (dig_q == DigCntW'(1)) begin
            state_d = StIdle;
          end
        end
      end
      default: state_d = StIdle;
    endcase
    out_valid_d = load ? 1'b1 : (out_valid_q && !out_o.ready);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
      step_q      <= '0;
      dig_q       <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      step_q      <= step_d;
      dig_q       <= dig_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q  <= mag_d;
    bcd_q  <= bcd_d;
    neg_q  <= neg_d;
    char_q <= char_d;
    last_q <= last_d;
  end

  `SB2DA_ASSERT(a_accept_starts_conv,
      (in_i.valid && in_i.ready) |=> (state_q == StConv),
      "accepted transaction did not start conversion")
  `SB2DA_ASSERT(a_sign_only_negative,
      (state_q == StSign) |-> neg_q,
      "minus sign for a non-negative value")
  `SB2DA_ASSERT(a_digit_count_live,
      (state_q == StDigs || state_q == StSkip) |-> (dig_q != '0),
      "digit count ran out while emitting")
  `SB2DA_ASSERT_ALWAYS(a_reset_empty,
      !rst_ni |=> !out_valid_q,
      "output register not empty in reset")

endmodule
